### src/msi_lru_cache_tag_store_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MSI LRU cache tag store
// Shared helpers that wrap concurrent assertions on aclk with reset gating.
// ----------------------------------------------------------------------------
`ifndef MSI_LRU_CACHE_TAG_STORE_MACROS_SVH
`define MSI_LRU_CACHE_TAG_STORE_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define MLCT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define MLCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mlct_pkg.sv
// ----------------------------------------------------------------------------
// mlct_pkg
// Types and codes shared by the tag store cells and the top level.
// ----------------------------------------------------------------------------
package mlct_pkg;

    // MSI line state codes.
    typedef enum logic [1:0] {
        LINE_I = 2'd0,
        LINE_S = 2'd1,
        LINE_M = 2'd2
    } line_state_t;

    // Request kinds carried in tuser.
    localparam logic REQ_LOCAL = 1'b0;
    localparam logic REQ_SNOOP = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_LOOKUP,
        CTL_UPDATE
    } ctl_state_t;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic lookup;       // compare the request tag and keep the match
        logic shift;        // local access: shift toward the tail up to the hit
        logic snoop;        // snoop from another cache: update matching line
        logic snoop_write;  // snoop is a write (invalidate)
    } cell_ctl_t;

    // Hit information handed from cell to cell toward the tail.
    typedef struct packed {
        logic        seen;       // a cell nearer the head matched
        line_state_t hit_state;  // state of the matching line
    } chain_info_t;

endpackage

### src/msi_lru_cache_tag_store.sv
// ----------------------------------------------------------------------------
// msi_lru_cache_tag_store
// Fully associative tag store with LRU replacement and MSI line states.
//
// Input items arrive on the s_ channel (tuser: request kind, tdata: write
// flag, address and source id); one result item per input leaves on the m_
// channel. The own cache id is written through cfg_wr_en / cfg_wr_data.
// Lines sit in a chain of cells kept in recency order, the head being the
// most recent. An item passes through a lookup state, in which every cell
// compares its tag, and an update state, in which the hit information ripples
// down the chain and the cells shift or update. The result is written into the
// output register in the update state, and a new item is accepted in that same
// update state, so the store takes the next item while finishing the last one.
// Reset (aresetn low, synchronous) empties all lines and clears own id.
// While the receiver stalls, one finished result waits in the output register
// and the next item may still be accepted; it then waits in its update cycle.
// ----------------------------------------------------------------------------
module msi_lru_cache_tag_store #(
    parameter int LINES    = 16,
    parameter int TAG_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // own_id
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,       // is_write[0], address[64:1], source_id[80:65]
    input  logic [0:0]  s_tuser,       // req_type[0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // hit[0], state_after[2:1], evicted[3],
                                       // evicted_tag[35:4], evicted_state[37:36],
                                       // writeback[38]
);
    import mlct_pkg::*;

`include "msi_lru_cache_tag_store_macros.svh"

    localparam int EvTagBits = (TAG_BITS < 32) ? TAG_BITS : 32;

    ctl_state_t          state_reg, state_next;
    logic [15:0]         own_id_reg;
    logic                req_type_reg;
    logic                is_write_reg;
    logic [TAG_BITS-1:0] req_tag_reg;
    logic [15:0]         src_id_reg;
    logic                m_tvalid_reg;
    logic [39:0]         m_tdata_reg;

    logic                s_accept;
    logic                out_free;
    logic                do_update;
    logic [63:0]         in_address;
    cell_ctl_t           ctl;

    logic                valid_c [LINES+1];
    logic [TAG_BITS-1:0] tag_c   [LINES+1];
    line_state_t         state_c [LINES+1];
    chain_info_t         chain   [LINES+1];
    logic [LINES-1:0]    valid_vec;

    logic                any_hit;
    line_state_t         hit_state;
    logic                full;
    line_state_t         new_state;
    logic                snoop_active;
    line_state_t         snoop_state;
    logic                res_hit;
    line_state_t         res_state;
    logic                res_evicted;
    logic [31:0]         res_ev_tag;
    line_state_t         res_ev_state;
    logic                res_writeback;

    assign in_address = s_tdata[64:1];
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;

    // Own cache id register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= '0;
        end else if (cfg_wr_en) begin
            own_id_reg <= cfg_wr_data;
        end
    end

    // Request fields are held for the lookup and update cycles.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_type_reg <= s_tuser[0];
            is_write_reg <= s_tdata[0];
            req_tag_reg  <= in_address[63 -: TAG_BITS];
            src_id_reg   <= s_tdata[80:65];
        end
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and cell commands.
    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        do_update       = 1'b0;
        ctl.lookup      = 1'b0;
        ctl.shift       = 1'b0;
        ctl.snoop       = 1'b0;
        ctl.snoop_write = is_write_reg;
        unique case (state_reg)
            CTL_IDLE: begin
                // No item is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = CTL_LOOKUP;
                end
            end
            CTL_LOOKUP: begin
                ctl.lookup = 1'b1;
                state_next = CTL_UPDATE;
            end
            CTL_UPDATE: begin
                if (out_free) begin
                    do_update  = 1'b1;
                    s_tready   = 1'b1;
                    ctl.shift  = (req_type_reg == REQ_LOCAL);
                    ctl.snoop  = snoop_active;
                    state_next = s_tvalid ? CTL_LOOKUP : CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // The head cell is fed the new entry of a local access.
    assign valid_c[0] = 1'b1;
    assign tag_c[0]   = req_tag_reg;
    assign state_c[0] = new_state;
    assign chain[0]   = '0;

    // Chain of line cells, most recent at the head.
    for (genvar i = 0; i < LINES; i++) begin : g_cell
        mlct_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .req_tag    (req_tag_reg),
            .prev_valid (valid_c[i]),
            .prev_tag   (tag_c[i]),
            .prev_state (state_c[i]),
            .chain_in   (chain[i]),
            .line_valid (valid_c[i+1]),
            .line_tag   (tag_c[i+1]),
            .line_state (state_c[i+1]),
            .chain_out  (chain[i+1])
        );
        assign valid_vec[i] = valid_c[i+1];
    end

    // Lookup summary from the tail of the chain; the tail is the LRU line.
    assign any_hit   = chain[LINES].seen;
    assign hit_state = chain[LINES].hit_state;
    assign full      = valid_c[LINES];

    // New state of a local access: writes go Modified, reads keep Modified.
    assign new_state = (is_write_reg || (any_hit && hit_state == LINE_M)) ? LINE_M : LINE_S;

    // Snoop handling: only a present line and a foreign id take effect.
    assign snoop_active = (req_type_reg == REQ_SNOOP) && any_hit && (src_id_reg != own_id_reg);
    assign snoop_state  = is_write_reg ? LINE_I :
                          ((hit_state == LINE_M) ? LINE_S : hit_state);

    // Result fields.
    always_comb begin
        res_hit       = 1'b0;
        res_state     = LINE_I;
        res_evicted   = 1'b0;
        res_ev_tag    = '0;
        res_ev_state  = LINE_I;
        res_writeback = 1'b0;
        if (req_type_reg == REQ_LOCAL) begin
            res_hit   = any_hit;
            res_state = new_state;
            if (!any_hit && full) begin
                res_evicted  = 1'b1;
                res_ev_tag   = 32'(tag_c[LINES][EvTagBits-1:0]);
                res_ev_state = state_c[LINES];
            end
        end else if (snoop_active) begin
            res_hit       = 1'b1;
            res_state     = snoop_state;
            res_writeback = !is_write_reg && (hit_state == LINE_M);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (do_update) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_update) begin
            m_tdata_reg <= {1'b0, res_writeback, res_ev_state, res_ev_tag,
                            res_evicted, res_state, res_hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Valid lines always form an unbroken run from the head.
    `MLCT_ASSERT_IMPL(a_valid_prefix, 1'b1,
        (((valid_vec + LINES'(1)) & valid_vec) == '0), "valid lines not contiguous")
    // Once every line is in use the store stays full.
    `MLCT_ASSERT_NEXT(a_full_stays, full, full, "full store lost a line")
    // A result appears only out of an update cycle.
    `MLCT_ASSERT_IMPL(a_result_src, $rose(m_tvalid_reg),
        ($past(state_reg) == CTL_UPDATE), "result without update")

endmodule

### src/mlct_cell.sv
// ----------------------------------------------------------------------------
// mlct_cell
// One line of the recency-ordered tag chain. The cell at the head holds the
// most recent line; on a local access every cell up to the hit loads its
// neighbor nearer the head, so the hit line leaves and the new entry enters.
// ----------------------------------------------------------------------------
module mlct_cell #(
    parameter int TAG_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mlct_pkg::cell_ctl_t       ctl,
    input  logic [TAG_BITS-1:0]       req_tag,
    input  logic                      prev_valid,
    input  logic [TAG_BITS-1:0]       prev_tag,
    input  mlct_pkg::line_state_t     prev_state,
    input  mlct_pkg::chain_info_t     chain_in,
    output logic                      line_valid,
    output logic [TAG_BITS-1:0]       line_tag,
    output mlct_pkg::line_state_t     line_state,
    output mlct_pkg::chain_info_t     chain_out
);
    import mlct_pkg::*;

    logic                valid_reg;
    logic                match_reg;
    logic [TAG_BITS-1:0] tag_reg;
    line_state_t         state_reg;
    logic                shift_en;
    line_state_t         snoop_state;

    // A cell shifts unless the hit lies nearer the head.
    assign shift_en = ctl.shift && !chain_in.seen;

    // Snoop write invalidates; snoop read downgrades Modified to Shared.
    assign snoop_state = ctl.snoop_write ? LINE_I :
                         ((state_reg == LINE_M) ? LINE_S : state_reg);

    // Control state: valid flag and the registered tag match.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctl.lookup) begin
                match_reg <= valid_reg && (tag_reg == req_tag);
            end
            if (shift_en) begin
                valid_reg <= prev_valid;
            end
        end
    end

    // Line payload: shifted in from the neighbor or updated by a snoop.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            tag_reg   <= prev_tag;
            state_reg <= prev_state;
        end else if (ctl.snoop && match_reg) begin
            state_reg <= snoop_state;
        end
    end

    // Pass the hit information on to the next cell.
    always_comb begin
        chain_out.seen      = chain_in.seen || match_reg;
        chain_out.hit_state = line_state_t'(chain_in.hit_state |
                                            (match_reg ? state_reg : LINE_I));
    end

    assign line_valid = valid_reg;
    assign line_tag   = tag_reg;
    assign line_state = state_reg;

endmodule
